// ----- rtl/core/pesh_pkg.sv -----
// pesh_pkg: types, codes and header-walk helpers for the PES header parser
// no dependencies; used by the channel interfaces, pesh_step and pes_header_parser
package pesh_pkg;

  // configuration port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // start code bytes
  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  // stream ids that carry no PES header
  localparam logic [7:0] SID_MAP      = 8'hBC;
  localparam logic [7:0] SID_PADDING  = 8'hBE;
  localparam logic [7:0] SID_PRIV2    = 8'hBF;
  localparam logic [7:0] SID_ECM      = 8'hF0;
  localparam logic [7:0] SID_EMM      = 8'hF1;
  localparam logic [7:0] SID_DSMCC    = 8'hF2;
  localparam logic [7:0] SID_H2221E   = 8'hF8;
  localparam logic [7:0] SID_DIRECTORY = 8'hFF;

  // reset values of the configuration registers
  localparam logic [5:0] GROUP_ID_RST = 6'h20;
  localparam logic       GROUP_EN_RST = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GROUP_ID = 2'd0,
    CFG_GROUP_EN = 2'd1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_SC0      = 5'd1,
    PH_SC1      = 5'd2,
    PH_SC2      = 5'd3,
    PH_SID      = 5'd4,
    PH_LENHI    = 5'd5,
    PH_LENLO    = 5'd6,
    PH_FL1      = 5'd7,
    PH_FL2      = 5'd8,
    PH_HDL      = 5'd9,
    PH_PTS      = 5'd10,
    PH_ESCR     = 5'd11,
    PH_ESR      = 5'd12,
    PH_DSM      = 5'd13,
    PH_ACI      = 5'd14,
    PH_CRC      = 5'd15,
    PH_EXT      = 5'd16,
    PH_PRIV     = 5'd17,
    PH_PACKLEN  = 5'd18,
    PH_PACK     = 5'd19,
    PH_PPSC     = 5'd20,
    PH_PSTD     = 5'd21,
    PH_E2LEN    = 5'd22,
    PH_E2ID     = 5'd23,
    PH_E2DATA   = 5'd24,
    PH_STUFF    = 5'd25,
    PH_GROUP    = 5'd26,
    PH_GRPHDR   = 5'd27,
    PH_PAYLOAD  = 5'd28,
    PH_SKIPBODY = 5'd29,
    PH_DROP     = 5'd30
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_PAYLOAD = 3'd1,
    KIND_SKIPPED = 3'd2,
    KIND_DISCARD = 3'd3,
    KIND_GROUP   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_BAD_GROUP = 2'd2,
    ST_OVERRUN   = 2'd3
  } status_t;

  // per-packet parser state
  typedef struct packed {
    phase_t      phase;
    logic [7:0]  field_count;
    logic [7:0]  stream_code;
    logic [7:0]  header_flags;
    logic [7:0]  extension_flags;
    logic [7:0]  header_left;
    logic [15:0] length_left;
    logic [6:0]  ext2_length;
    status_t     error_code;
  } pesh_state_t;

  // one result beat
  typedef struct packed {
    logic [7:0]  out_byte;
    kind_t       byte_kind;
    logic [7:0]  sid_seen;
    logic [1:0]  timestamp_code;
    logic [15:0] bytes_left;
    status_t     status;
    logic        end_flag;
  } pesh_result_t;

  // configuration seen by the step logic
  typedef struct packed {
    logic [5:0] group_id;
    logic       group_en;
  } pesh_cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] field_count;
  } pesh_adv_t;

  function automatic logic is_headerless(input logic [7:0] sid);
    return sid inside {SID_MAP, SID_PADDING, SID_PRIV2, SID_ECM, SID_EMM,
                       SID_DSMCC, SID_H2221E, SID_DIRECTORY};
  endfunction

  // byte count of an optional header field, zero when the field is absent
  function automatic logic [7:0] stage_len(input phase_t p, input logic [7:0] hf,
                                           input logic [7:0] ef, input logic [7:0] fc);
    logic [7:0] n;
    n = 8'd0;
    case (p)
      PH_PTS: begin
        if (hf[7:6] == 2'b10) n = 8'd5;
        else if (hf[7:6] == 2'b11) n = 8'd10;
      end
      PH_ESCR:    n = hf[5] ? 8'd6 : 8'd0;
      PH_ESR:     n = hf[4] ? 8'd3 : 8'd0;
      PH_DSM:     n = hf[3] ? 8'd1 : 8'd0;
      PH_ACI:     n = hf[2] ? 8'd1 : 8'd0;
      PH_CRC:     n = hf[1] ? 8'd2 : 8'd0;
      PH_EXT:     n = hf[0] ? 8'd1 : 8'd0;
      PH_PRIV:    n = ef[7] ? 8'd16 : 8'd0;
      PH_PACKLEN: n = ef[6] ? 8'd1 : 8'd0;
      PH_PACK:    n = fc;
      PH_PPSC:    n = ef[5] ? 8'd2 : 8'd0;
      PH_PSTD:    n = ef[4] ? 8'd2 : 8'd0;
      PH_E2LEN:   n = ef[0] ? 8'd1 : 8'd0;
      PH_E2ID:    n = ef[0] ? 8'd1 : 8'd0;
      PH_E2DATA:  n = fc;
      default:    n = 8'd0;
    endcase
    return n;
  endfunction

  // first present field at or after start; else stuffing, group header or payload
  function automatic pesh_adv_t advance(input phase_t start, input logic [7:0] hf,
                                        input logic [7:0] ef, input logic [7:0] fc,
                                        input logic [7:0] hl, input logic gce);
    pesh_adv_t  res;
    logic       found;
    logic [7:0] n;
    phase_t     p;
    found = 1'b0;
    res.field_count = 8'd0;
    if (hl != 8'd0) res.phase = PH_STUFF;
    else if (gce)   res.phase = PH_GROUP;
    else            res.phase = PH_PAYLOAD;
    for (int i = PH_PTS; i <= PH_E2DATA; i++) begin
      p = phase_t'(5'(i));
      n = stage_len(p, hf, ef, fc);
      if (!found && (p >= start) && (n != 8'd0)) begin
        found = 1'b1;
        res.phase = p;
        res.field_count = n;
      end
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/pesh_ifs.sv -----
// pesh_ifs: valid/ready channel interfaces of the PES header parser
// depends on pesh_pkg for the configuration port widths
interface pesh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       packet_begin;
  modport source (output valid, in_byte, packet_begin, input ready);
  modport sink (input valid, in_byte, packet_begin, output ready);
endinterface

interface pesh_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [2:0]  byte_kind;
  logic [7:0]  sid_seen;
  logic [1:0]  timestamp_code;
  logic [15:0] bytes_left;
  logic [1:0]  status;
  logic        end_flag;
  modport source (output valid, out_byte, byte_kind, sid_seen, timestamp_code,
                  bytes_left, status, end_flag, input ready);
  modport sink (input valid, out_byte, byte_kind, sid_seen, timestamp_code,
                bytes_left, status, end_flag, output ready);
endinterface

interface pesh_cfg_if;
  import pesh_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/pes_header_parser.sv -----
// pes_header_parser: byte-serial MPEG-2 PES header parser, top level
// depends on pesh_pkg, pesh_ifs (channel interfaces) and pesh_step
//
// Usage: bytes of a PES stream arrive on in_if, one beat per byte, with
// packet_begin set on the first start code byte of each packet. Every
// accepted beat yields exactly one result beat on out_if carrying the byte,
// its kind (header, payload, skipped body, discarded, group header), the
// stream id, PTS/DTS flags, remaining packet length, sticky status and an
// end flag on the last byte of the packet.
// cfg_if writes expected_group_id (index 0) and group_check_enable
// (index 1); it is always ready and should be written only while idle.
// A result beat is registered and valid in the cycle after its input beat;
// throughput is one byte per cycle while out_if is ready, set by the single
// result register; in_if.ready is high whenever it is empty or being read,
// so a stalled receiver holds the result and stops input until it drains.
// Reset (rst_n low, synchronous) empties the result register, puts the
// parser idle with all per-packet state cleared, and loads the register
// defaults (group id 0x20, check enabled).
module pes_header_parser (
  input  logic         clk,
  input  logic         rst_n,
  pesh_in_if.sink      in_if,
  pesh_out_if.source   out_if,
  pesh_cfg_if.sink     cfg_if
);
  import pesh_pkg::*;

  pesh_state_t  state_r;
  pesh_state_t  state_nxt;
  pesh_cfg_t    cfg_r;
  pesh_result_t res_r;
  pesh_result_t res_nxt;
  logic         out_valid_r;
  logic         in_fire;

  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign in_fire      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  pesh_step u_step (
    .cur_state    (state_r),
    .cfg          (cfg_r),
    .in_byte      (in_if.in_byte),
    .packet_begin (in_if.packet_begin),
    .nxt_state    (state_nxt),
    .result       (res_nxt)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.group_id <= GROUP_ID_RST;
      cfg_r.group_en <= GROUP_EN_RST;
    end else if (cfg_if.valid) begin
      case (cfg_reg_t'(cfg_if.index))
        CFG_GROUP_ID: cfg_r.group_id <= cfg_if.data[5:0];
        CFG_GROUP_EN: cfg_r.group_en <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  // parser state, advanced on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.out_byte       = res_r.out_byte;
  assign out_if.byte_kind      = res_r.byte_kind;
  assign out_if.sid_seen       = res_r.sid_seen;
  assign out_if.timestamp_code = res_r.timestamp_code;
  assign out_if.bytes_left     = res_r.bytes_left;
  assign out_if.status         = res_r.status;
  assign out_if.end_flag       = res_r.end_flag;

endmodule

// ----- rtl/core/pesh_step.sv -----
// pesh_step: next-state and result logic for one stream byte
// depends on pesh_pkg (state, result and config types, advance helper)
module pesh_step (
  input  pesh_pkg::pesh_state_t  cur_state,
  input  pesh_pkg::pesh_cfg_t    cfg,
  input  logic [7:0]             in_byte,
  input  logic                   packet_begin,
  output pesh_pkg::pesh_state_t  nxt_state,
  output pesh_pkg::pesh_result_t result
);
  import pesh_pkg::*;

  pesh_state_t st;
  pesh_state_t nx;
  pesh_adv_t   adv;
  kind_t       kind;
  status_t     err;
  logic        endf;
  logic [7:0]  sc_exp;
  logic [15:0] len;
  logic [7:0]  fc;
  logic [7:0]  hl;

  // per-byte transition
  always_comb begin
    adv    = '0;
    sc_exp = SC_ZERO;
    len    = '0;
    fc     = '0;
    hl     = '0;
    // packet begin clears all per-packet state
    if (packet_begin) begin
      st = '0;
      st.phase = PH_SC0;
    end else begin
      st = cur_state;
    end
    nx   = st;
    kind = KIND_HEADER;
    endf = 1'b0;
    err  = st.error_code;

    case (st.phase)
      PH_SC0, PH_SC1, PH_SC2: begin
        sc_exp = (st.phase == PH_SC2) ? SC_ONE : SC_ZERO;
        if (in_byte != sc_exp) begin
          if (err == ST_OK) err = ST_BAD_START;
          nx.phase = PH_IDLE;
        end else begin
          nx.phase = phase_t'(st.phase + 5'd1);
        end
      end
      PH_SID: begin
        nx.stream_code = in_byte;
        nx.phase = PH_LENHI;
      end
      PH_LENHI: begin
        nx.length_left = {in_byte, 8'h00};
        nx.phase = PH_LENLO;
      end
      PH_LENLO: begin
        len = {st.length_left[15:8], in_byte};
        nx.length_left = len;
        if (len == 16'd0) begin
          if (!is_headerless(st.stream_code) && err == ST_OK) err = ST_OVERRUN;
          endf = 1'b1;
          nx.phase = PH_IDLE;
        end else begin
          nx.phase = is_headerless(st.stream_code) ? PH_SKIPBODY : PH_FL1;
        end
      end
      PH_FL1: nx.phase = PH_FL2;
      PH_FL2: begin
        nx.header_flags = in_byte;
        nx.phase = PH_HDL;
      end
      PH_HDL: begin
        nx.header_left = in_byte;
        adv = advance(PH_PTS, st.header_flags, st.extension_flags, st.field_count,
                      in_byte, cfg.group_en);
        nx.phase = adv.phase;
        nx.field_count = adv.field_count;
      end
      PH_STUFF: begin
        hl = (st.header_left != 8'd0) ? st.header_left - 8'd1 : 8'd0;
        nx.header_left = hl;
        adv = advance(PH_STUFF, st.header_flags, st.extension_flags, st.field_count,
                      hl, cfg.group_en);
        nx.phase = adv.phase;
        nx.field_count = adv.field_count;
      end
      PH_GROUP: begin
        kind = KIND_GROUP;
        if (in_byte[7:2] != cfg.group_id) begin
          if (err == ST_OK) err = ST_BAD_GROUP;
          nx.phase = PH_DROP;
        end else begin
          nx.field_count = 8'd2;
          nx.phase = PH_GRPHDR;
        end
      end
      PH_GRPHDR: begin
        kind = KIND_GROUP;
        fc = (st.field_count != 8'd0) ? st.field_count - 8'd1 : 8'd0;
        nx.field_count = fc;
        if (fc == 8'd0) nx.phase = PH_PAYLOAD;
      end
      PH_PAYLOAD:  kind = KIND_PAYLOAD;
      PH_SKIPBODY: kind = KIND_SKIPPED;
      PH_DROP, PH_IDLE: kind = KIND_DISCARD;
      PH_PTS, PH_ESCR, PH_ESR, PH_DSM, PH_ACI, PH_CRC, PH_EXT, PH_PRIV,
      PH_PACKLEN, PH_PACK, PH_PPSC, PH_PSTD, PH_E2LEN, PH_E2ID, PH_E2DATA: begin
        // optional field byte: count down header and field
        if (st.header_left == 8'd0) begin
          if (err == ST_OK) err = ST_OVERRUN;
          hl = 8'd0;
        end else begin
          hl = st.header_left - 8'd1;
        end
        nx.header_left = hl;
        if (st.phase == PH_EXT) nx.extension_flags = in_byte;
        else if (st.phase == PH_E2LEN) nx.ext2_length = in_byte[6:0];
        fc = (st.field_count != 8'd0) ? st.field_count - 8'd1 : 8'd0;
        nx.field_count = fc;
        if (fc == 8'd0) begin
          if (st.phase == PH_PACKLEN) fc = in_byte;
          else if (st.phase == PH_E2ID) fc = in_byte[7] ? 8'd0 : {1'b0, st.ext2_length};
          adv = advance(phase_t'(st.phase + 5'd1), st.header_flags, nx.extension_flags,
                        fc, hl, cfg.group_en);
          nx.phase = adv.phase;
          nx.field_count = adv.field_count;
        end
      end
      default: begin
        kind = KIND_DISCARD;
        nx.phase = PH_IDLE;
      end
    endcase

    // packet length countdown once the length is known
    if (st.phase >= PH_FL1) begin
      if (st.length_left != 16'd0) nx.length_left = st.length_left - 16'd1;
      if (nx.length_left == 16'd0) begin
        if (nx.phase >= PH_FL1 && nx.phase <= PH_STUFF && err == ST_OK) err = ST_OVERRUN;
        endf = 1'b1;
        nx.phase = PH_IDLE;
      end
    end

    nx.error_code = err;
  end

  assign nxt_state = nx;

  // result beat fields
  always_comb begin
    result.out_byte       = in_byte;
    result.byte_kind      = kind;
    result.sid_seen       = nx.stream_code;
    result.timestamp_code = nx.header_flags[7:6];
    result.bytes_left     = nx.length_left;
    result.status         = err;
    result.end_flag       = endf;
  end

endmodule
